// ===== sv/pprds_pkg.sv =====
// Shared types, constants and arithmetic step functions of the per-pixel depth statistics unit.
`default_nettype none

package pprds_pkg;

    localparam int IDX_W   = 19;
    localparam int DEPTH_W = 16;
    localparam int CNT_W   = 16;
    localparam int MEAN_W  = 32;
    localparam int M2_W    = 64;
    localparam int STDEV_W = 24;
    localparam int FRAC_W  = 16;

    localparam logic [CNT_W-1:0]   COUNT_MAX = '1;
    localparam logic [STDEV_W-1:0] STDEV_MAX = '1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    // Quotient or root bits resolved per pipeline stage.
    localparam int BITS_PER_STAGE = 2;
    localparam int REM_W          = CNT_W;
    localparam int MDIV_STAGES    = MEAN_W / BITS_PER_STAGE;
    localparam int VDIV_STAGES    = M2_W / BITS_PER_STAGE;
    localparam int ROOT_W         = M2_W / 2;
    localparam int SQ_REM_W       = ROOT_W + 1;
    localparam int SQRT_STAGES    = ROOT_W / BITS_PER_STAGE;

    typedef struct packed {
        logic [IDX_W-1:0]   pixel_index;
        logic [DEPTH_W-1:0] depth_mm;
        logic               restart;
        logic               in_range;
    } req_t;

    typedef struct packed {
        logic [CNT_W-1:0]  cnt;
        logic [MEAN_W-1:0] mean;
        logic [M2_W-1:0]   m2;
    } entry_t;

    typedef struct packed {
        logic [IDX_W-1:0]  pixel_index;
        logic              in_range;
        logic              upd;
        entry_t            old;
        logic [CNT_W-1:0]  cnt_inc;
        logic [MEAN_W-1:0] zq;
        logic [MEAN_W-1:0] mag;
        logic              ge;
    } wel_t;

    typedef struct packed {
        wel_t              w;
        logic [REM_W-1:0]  rem;
        logic [MEAN_W-1:0] num;
        logic [MEAN_W-1:0] quo;
    } mdiv_t;

    typedef struct packed {
        wel_t              w;
        logic [MEAN_W-1:0] new_mean;
        logic [MEAN_W-1:0] mag2;
        logic [M2_W-1:0]   prod;
    } mmul_t;

    typedef struct packed {
        logic              low_cnt;
        logic [CNT_W-1:0]  cnt;
        logic [MEAN_W-1:0] mean;
        logic [CNT_W-1:0]  den;
        logic [REM_W-1:0]  rem;
        logic [M2_W-1:0]   num;
        logic [M2_W-1:0]   quo;
    } vdiv_t;

    typedef struct packed {
        logic                low_cnt;
        logic [CNT_W-1:0]    cnt;
        logic [MEAN_W-1:0]   mean;
        logic [M2_W-1:0]     rad;
        logic [SQ_REM_W-1:0] rem;
        logic [ROOT_W-1:0]   root;
    } sqrt_t;

    typedef struct packed {
        logic [CNT_W-1:0]   cnt;
        logic [MEAN_W-1:0]  mean;
        logic [STDEV_W-1:0] stdev;
    } rsp_t;

    typedef struct packed {
        logic not_empty;
        logic full;
    } q_status_t;

    typedef struct packed {
        logic clr_busy;
        logic hazard;
        logic issue;
    } upd_status_t;

    // One restoring division step: returns {quotient bit, new remainder}.
    function automatic logic [REM_W:0] div_step(input logic [REM_W-1:0] rem,
                                                 input logic nb,
                                                 input logic [REM_W-1:0] den);
        logic [REM_W:0] s;
        logic [REM_W:0] d;
        s = {rem, nb};
        d = s - {1'b0, den};
        if (s >= {1'b0, den})
        begin
            return {1'b1, d[REM_W-1:0]};
        end
        return {1'b0, s[REM_W-1:0]};
    endfunction

    // One restoring square root step on two radicand bits: returns {root, remainder}.
    function automatic logic [ROOT_W+SQ_REM_W-1:0] sqrt_step(input logic [SQ_REM_W-1:0] rem,
                                                             input logic [1:0] nb,
                                                             input logic [ROOT_W-1:0] root);
        logic [SQ_REM_W+1:0] s;
        logic [SQ_REM_W+1:0] t;
        logic [SQ_REM_W+1:0] d;
        s = {rem, nb};
        t = {1'b0, root, 2'b01};
        d = s - t;
        if (s >= t)
        begin
            return {root[ROOT_W-2:0], 1'b1, d[SQ_REM_W-1:0]};
        end
        return {root[ROOT_W-2:0], 1'b0, s[SQ_REM_W-1:0]};
    endfunction

endpackage

`default_nettype wire

// ===== sv/pprds_if.sv =====
// Request and result channel interfaces of the per-pixel depth statistics unit.
`default_nettype none

interface pprds_in_if;
    import pprds_pkg::*;

    logic               valid;
    logic               ready;
    logic [IDX_W-1:0]   pixel_index;
    logic [DEPTH_W-1:0] depth_mm;
    logic               restart;

    modport source (output valid, output pixel_index, output depth_mm, output restart,
                    input ready);
    modport sink (input valid, input pixel_index, input depth_mm, input restart,
                  output ready);
endinterface

interface pprds_out_if;
    import pprds_pkg::*;

    logic               valid;
    logic               ready;
    logic [CNT_W-1:0]   sample_count;
    logic [MEAN_W-1:0]  mean_depth_q16;
    logic [STDEV_W-1:0] stdev_q8;

    modport source (output valid, output sample_count, output mean_depth_q16,
                    output stdev_q8, input ready);
    modport sink (input valid, input sample_count, input mean_depth_q16,
                  input stdev_q8, output ready);
endinterface

`default_nettype wire

// ===== sv/pprds_front.sv =====
// Front end: takes requests, checks the pixel range and hands them to the queue.
`default_nettype none

module pprds_front #(
    parameter int FRAME_WIDTH  = 640,
    parameter int FRAME_HEIGHT = 480
) (
    pprds_in_if.sink              pixel,
    input  logic                  clr_busy,
    input  pprds_pkg::q_status_t  q_stat,
    output logic                  push,
    output pprds_pkg::req_t       push_req
);
    import pprds_pkg::*;

    localparam int unsigned PIXEL_COUNT = FRAME_WIDTH * FRAME_HEIGHT;

    assign pixel.ready = !clr_busy && !q_stat.full;
    assign push        = pixel.valid && pixel.ready;

    always_comb
    begin
        push_req.pixel_index = pixel.pixel_index;
        push_req.depth_mm    = pixel.depth_mm;
        push_req.restart     = pixel.restart;
        push_req.in_range    = 32'(pixel.pixel_index) < 32'(PIXEL_COUNT);
    end

endmodule

`default_nettype wire

// ===== sv/pprds_queue.sv =====
// Short request queue between the front end and the update pipeline.
`default_nettype none

module pprds_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  pprds_pkg::req_t       push_req,
    input  logic                  pop,
    output pprds_pkg::req_t       head,
    output pprds_pkg::q_status_t  q_stat
);
    import pprds_pkg::*;

    req_t              q_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic [QPTR_W:0]   count_next;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= push_req;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    assign head             = q_mem[rd_ptr_reg];
    assign q_stat.not_empty = (count_reg != '0);
    assign q_stat.full      = (count_reg == (QPTR_W + 1)'(QUEUE_DEPTH));

endmodule

`default_nettype wire

// ===== sv/pprds_update.sv =====
// Back end, first half: statistics memory, clearing pass and the Welford update pipeline.
`default_nettype none

module pprds_update #(
    parameter int FRAME_WIDTH  = 640,
    parameter int FRAME_HEIGHT = 480
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    adv,
    input  pprds_pkg::req_t         head,
    input  pprds_pkg::q_status_t    q_stat,
    output pprds_pkg::upd_status_t  status,
    output logic                    res_valid,
    output pprds_pkg::entry_t       res
);
    import pprds_pkg::*;

    localparam int unsigned PIXEL_COUNT = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int unsigned MEM_DEPTH   = (PIXEL_COUNT < (1 << IDX_W)) ? PIXEL_COUNT
                                                                       : (1 << IDX_W);
    localparam int ADDR_W = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

    function automatic mdiv_t mdiv_advance(input mdiv_t d);
        mdiv_t          o;
        logic [REM_W:0] r;
        o = d;
        for (int b = 0; b < BITS_PER_STAGE; b++)
        begin
            r     = div_step(o.rem, o.num[MEAN_W-1], o.w.cnt_inc);
            o.rem = r[REM_W-1:0];
            o.quo = {o.quo[MEAN_W-2:0], r[REM_W]};
            o.num = {o.num[MEAN_W-2:0], 1'b0};
        end
        return o;
    endfunction

    entry_t            mem [MEM_DEPTH];
    entry_t            rd_reg;
    logic              clr_busy_reg;
    logic [ADDR_W-1:0] clr_addr_reg;

    logic                   s1_valid_reg;
    req_t                   s1_reg;
    logic [MDIV_STAGES-1:0] dv_valid_reg;
    mdiv_t                  dv_reg  [MDIV_STAGES];
    mdiv_t                  dv_next [MDIV_STAGES];
    logic                   m0_valid_reg;
    mmul_t                  m0_reg;
    mmul_t                  m0_next;
    logic                   m1_valid_reg;
    mmul_t                  m1_reg;
    mmul_t                  m1_next;
    logic                   res_valid_reg;
    entry_t                 res_reg;

    wel_t          w1;
    entry_t        wr_entry;
    logic          wr_en;
    logic          hazard;
    logic          issue;
    logic [M2_W:0] m2_sum;

    // Stage one: apply restart, form the new count and the distance to the mean.
    always_comb
    begin
        entry_t old;
        old = (s1_reg.restart || !s1_reg.in_range) ? '0 : rd_reg;
        w1.pixel_index = s1_reg.pixel_index;
        w1.in_range    = s1_reg.in_range;
        w1.upd         = s1_reg.in_range && (s1_reg.depth_mm != '0);
        w1.old         = old;
        w1.cnt_inc     = (old.cnt == COUNT_MAX) ? old.cnt : old.cnt + 1'b1;
        w1.zq          = {s1_reg.depth_mm, {FRAC_W{1'b0}}};
        w1.ge          = (w1.zq >= old.mean);
        w1.mag         = w1.ge ? (w1.zq - old.mean) : (old.mean - w1.zq);
    end

    always_comb
    begin
        mdiv_t init;
        init.w   = w1;
        init.rem = '0;
        init.num = w1.mag;
        init.quo = '0;
        dv_next[0] = mdiv_advance(init);
        for (int i = 1; i < MDIV_STAGES; i++)
        begin
            dv_next[i] = mdiv_advance(dv_reg[i-1]);
        end
    end

    always_comb
    begin
        mdiv_t d;
        d = dv_reg[MDIV_STAGES-1];
        m0_next.w        = d.w;
        m0_next.new_mean = d.w.ge ? (d.w.old.mean + d.quo) : (d.w.old.mean - d.quo);
        m0_next.mag2     = (d.w.zq >= m0_next.new_mean) ? (d.w.zq - m0_next.new_mean)
                                                        : (m0_next.new_mean - d.w.zq);
        m0_next.prod     = '0;
    end

    always_comb
    begin
        m1_next      = m0_reg;
        m1_next.prod = m0_reg.w.mag * m0_reg.mag2;
    end

    // Last stage: saturating M2 accumulation and write-back.
    always_comb
    begin
        m2_sum = {1'b0, m1_reg.w.old.m2} + {{(FRAC_W + 1){1'b0}}, m1_reg.prod[M2_W-1:FRAC_W]};
        if (m1_reg.w.upd)
        begin
            wr_entry.cnt  = m1_reg.w.cnt_inc;
            wr_entry.mean = m1_reg.new_mean;
            wr_entry.m2   = m2_sum[M2_W] ? '1 : m2_sum[M2_W-1:0];
        end
        else
        begin
            wr_entry = m1_reg.w.old;
        end
        wr_en = adv && m1_valid_reg && m1_reg.w.in_range;
    end

    // A pixel that is still on its way to write-back may not be read again.
    always_comb
    begin
        hazard = s1_valid_reg && (s1_reg.pixel_index == head.pixel_index);
        for (int i = 0; i < MDIV_STAGES; i++)
        begin
            if (dv_valid_reg[i] && (dv_reg[i].w.pixel_index == head.pixel_index))
            begin
                hazard = 1'b1;
            end
        end
        if (m0_valid_reg && (m0_reg.w.pixel_index == head.pixel_index))
        begin
            hazard = 1'b1;
        end
        if (m1_valid_reg && (m1_reg.w.pixel_index == head.pixel_index))
        begin
            hazard = 1'b1;
        end
    end

    assign issue = adv && q_stat.not_empty && !hazard && !clr_busy_reg;

    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            mem[clr_addr_reg] <= '0;
        end
        else if (wr_en)
        begin
            mem[m1_reg.w.pixel_index[ADDR_W-1:0]] <= wr_entry;
        end
        if (adv)
        begin
            rd_reg <= mem[head.pixel_index[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clr_busy_reg)
        begin
            if (clr_addr_reg == ADDR_W'(MEM_DEPTH - 1))
            begin
                clr_busy_reg <= 1'b0;
            end
            else
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            dv_valid_reg  <= '0;
            m0_valid_reg  <= 1'b0;
            m1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= issue;
            dv_valid_reg  <= {dv_valid_reg[MDIV_STAGES-2:0], s1_valid_reg};
            m0_valid_reg  <= dv_valid_reg[MDIV_STAGES-1];
            m1_valid_reg  <= m0_valid_reg;
            res_valid_reg <= m1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg <= head;
            for (int i = 0; i < MDIV_STAGES; i++)
            begin
                dv_reg[i] <= dv_next[i];
            end
            m0_reg  <= m0_next;
            m1_reg  <= m1_next;
            res_reg <= wr_entry;
        end
    end

    assign status.clr_busy = clr_busy_reg;
    assign status.hazard   = hazard;
    assign status.issue    = issue;
    assign res_valid       = res_valid_reg;
    assign res             = res_reg;

endmodule

`default_nettype wire

// ===== sv/pprds_stdev.sv =====
// Back end, second half: variance divider, square root pipeline and result buffer.
`default_nettype none

module pprds_stdev (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               res_valid,
    input  pprds_pkg::entry_t  res,
    output logic               adv,
    pprds_out_if.source        stats
);
    import pprds_pkg::*;

    function automatic vdiv_t vdiv_advance(input vdiv_t d);
        vdiv_t          o;
        logic [REM_W:0] r;
        o = d;
        for (int b = 0; b < BITS_PER_STAGE; b++)
        begin
            r     = div_step(o.rem, o.num[M2_W-1], o.den);
            o.rem = r[REM_W-1:0];
            o.quo = {o.quo[M2_W-2:0], r[REM_W]};
            o.num = {o.num[M2_W-2:0], 1'b0};
        end
        return o;
    endfunction

    function automatic sqrt_t sqrt_advance(input sqrt_t d);
        sqrt_t                       o;
        logic [ROOT_W+SQ_REM_W-1:0] r;
        o = d;
        for (int b = 0; b < BITS_PER_STAGE; b++)
        begin
            r      = sqrt_step(o.rem, o.rad[M2_W-1:M2_W-2], o.root);
            o.root = r[ROOT_W+SQ_REM_W-1:SQ_REM_W];
            o.rem  = r[SQ_REM_W-1:0];
            o.rad  = {o.rad[M2_W-3:0], 2'b00};
        end
        return o;
    endfunction

    logic [VDIV_STAGES-1:0] vd_valid_reg;
    vdiv_t                  vd_reg  [VDIV_STAGES];
    vdiv_t                  vd_next [VDIV_STAGES];
    logic [SQRT_STAGES-1:0] sq_valid_reg;
    sqrt_t                  sq_reg  [SQRT_STAGES];
    sqrt_t                  sq_next [SQRT_STAGES];

    rsp_t       ob_reg [2];
    logic       ob_wr_reg;
    logic       ob_rd_reg;
    logic [1:0] ob_cnt_reg;
    logic       ob_push;
    logic       ob_pop;
    rsp_t       rsp;

    always_comb
    begin
        vdiv_t init;
        init.low_cnt = (res.cnt <= CNT_W'(1));
        init.cnt     = res.cnt;
        init.mean    = res.mean;
        init.den     = init.low_cnt ? CNT_W'(1) : (res.cnt - 1'b1);
        init.rem     = '0;
        init.num     = res.m2;
        init.quo     = '0;
        vd_next[0]   = vdiv_advance(init);
        for (int i = 1; i < VDIV_STAGES; i++)
        begin
            vd_next[i] = vdiv_advance(vd_reg[i-1]);
        end
    end

    always_comb
    begin
        sqrt_t init;
        init.low_cnt = vd_reg[VDIV_STAGES-1].low_cnt;
        init.cnt     = vd_reg[VDIV_STAGES-1].cnt;
        init.mean    = vd_reg[VDIV_STAGES-1].mean;
        init.rad     = vd_reg[VDIV_STAGES-1].quo;
        init.rem     = '0;
        init.root    = '0;
        sq_next[0]   = sqrt_advance(init);
        for (int i = 1; i < SQRT_STAGES; i++)
        begin
            sq_next[i] = sqrt_advance(sq_reg[i-1]);
        end
    end

    always_comb
    begin
        sqrt_t s;
        s        = sq_reg[SQRT_STAGES-1];
        rsp.cnt  = s.cnt;
        rsp.mean = s.mean;
        if (s.low_cnt)
        begin
            rsp.stdev = '0;
        end
        else if (|s.root[ROOT_W-1:STDEV_W])
        begin
            rsp.stdev = STDEV_MAX;
        end
        else
        begin
            rsp.stdev = s.root[STDEV_W-1:0];
        end
    end

    assign adv     = (ob_cnt_reg != 2'd2);
    assign ob_push = adv && sq_valid_reg[SQRT_STAGES-1];
    assign ob_pop  = stats.valid && stats.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vd_valid_reg <= '0;
            sq_valid_reg <= '0;
            ob_wr_reg    <= 1'b0;
            ob_rd_reg    <= 1'b0;
            ob_cnt_reg   <= '0;
        end
        else
        begin
            if (adv)
            begin
                vd_valid_reg <= {vd_valid_reg[VDIV_STAGES-2:0], res_valid};
                sq_valid_reg <= {sq_valid_reg[SQRT_STAGES-2:0], vd_valid_reg[VDIV_STAGES-1]};
            end
            if (ob_push)
            begin
                ob_wr_reg <= !ob_wr_reg;
            end
            if (ob_pop)
            begin
                ob_rd_reg <= !ob_rd_reg;
            end
            ob_cnt_reg <= ob_cnt_reg + {1'b0, ob_push} - {1'b0, ob_pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < VDIV_STAGES; i++)
            begin
                vd_reg[i] <= vd_next[i];
            end
            for (int i = 0; i < SQRT_STAGES; i++)
            begin
                sq_reg[i] <= sq_next[i];
            end
        end
        if (ob_push)
        begin
            ob_reg[ob_wr_reg] <= rsp;
        end
    end

    assign stats.valid          = (ob_cnt_reg != '0);
    assign stats.sample_count   = ob_reg[ob_rd_reg].cnt;
    assign stats.mean_depth_q16 = ob_reg[ob_rd_reg].mean;
    assign stats.stdev_q8       = ob_reg[ob_rd_reg].stdev;

endmodule

`default_nettype wire

// ===== sv/per_pixel_running_depth_stats_unit.sv =====
// An accepted request passes the update, variance and square root pipelines to the output.
// Throughput: one request per cycle while the queue has room and no clear runs; a request
//   for a pixel still in the update pipeline waits until that pixel is written back at the
//   end of the mean divider and the M2 multiply-accumulate stages.
// Reset: the statistics memory is swept to zero, one entry per pixel of the frame, and no
//   request is accepted until the sweep ends.
`default_nettype none

// Per-pixel running depth statistics (Welford mean and variance per pixel).
//
// The front end accepts one request per cycle while the queue has room, checks the
// pixel index against the frame size and writes the request into a four-entry queue.
// The update pipeline pops the queue, reads the pixel's entry from the statistics
// memory, applies restart, and folds a nonzero depth into count, mean and M2. The mean
// step is a pipelined restoring divider with two quotient bits per stage; M2 grows by
// the product of the old and new distances to the mean, saturating. The entry is written
// back at the end of that pipeline, so a pixel still in flight blocks a new read of it.
//
// The statistics pipeline then divides M2 by count minus one (pipelined, two bits per
// stage), takes the integer square root (pipelined, two root bits per stage) and
// saturates the standard deviation. A two-entry result buffer lets the back end keep
// moving while one finished result waits to be taken. Both back-end pipelines advance
// together and only stop when that buffer is full.
module per_pixel_running_depth_stats_unit #(
    parameter int FRAME_WIDTH  = 640,
    parameter int FRAME_HEIGHT = 480
) (
    input  logic        clk,
    input  logic        rst_n,
    pprds_in_if.sink    pixel,
    pprds_out_if.source stats
);
    import pprds_pkg::*;

    logic        adv;
    logic        push;
    req_t        push_req;
    req_t        q_head;
    q_status_t   q_stat;
    upd_status_t upd_status;
    logic        res_valid;
    entry_t      res;

    // Request intake and range classification.
    pprds_front #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT)
    ) u_front (
        .pixel    (pixel),
        .clr_busy (upd_status.clr_busy),
        .q_stat   (q_stat),
        .push     (push),
        .push_req (push_req)
    );

    // Decouples intake from the update pipeline, which stalls on same-pixel hazards.
    pprds_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_req (push_req),
        .pop      (upd_status.issue),
        .head     (q_head),
        .q_stat   (q_stat)
    );

    // Memory, clearing sweep and Welford update.
    pprds_update #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT)
    ) u_update (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .head      (q_head),
        .q_stat    (q_stat),
        .status    (upd_status),
        .res_valid (res_valid),
        .res       (res)
    );

    // Variance, square root and result buffer.
    pprds_stdev u_stdev (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .adv       (adv),
        .stats     (stats)
    );

    // No request may enter while the memory is being cleared.
    a_no_accept_during_clear: assert property (@(posedge clk) disable iff (!rst_n)
        upd_status.clr_busy |-> !pixel.ready)
        else $error("request accepted during memory clear");

    // An issue needs a queued request, no pending write-back of that pixel and a moving pipe.
    a_issue_clean: assert property (@(posedge clk) disable iff (!rst_n)
        upd_status.issue |-> (q_stat.not_empty && !upd_status.hazard && adv))
        else $error("request issued under hazard or stall");

    // The queue is still empty when the clearing sweep finishes.
    a_queue_empty_after_clear: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(upd_status.clr_busy) |-> !q_stat.not_empty)
        else $error("queue filled during memory clear");

endmodule

`default_nettype wire
